@@ rtl/core/refdc_pkg.sv @@
// Shared types and constants for the radius edge filter with degree cap.
// Holds field widths, status and register codes and the configuration struct.
// No dependencies.
package refdc_pkg;

  localparam int ROW_W          = 10;
  localparam int DIST_W         = 32;
  localparam int MINW_W         = 31;
  localparam int DEG_W          = 16;
  localparam int CNT_W          = 17;
  localparam int SLOT_W         = 16;
  localparam int FILT_W         = 20;
  localparam int ST_W           = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int S_TDATA_W      = 56;
  localparam int S_TUSER_W      = 2;
  localparam int M_PAYLOAD_W    = SLOT_W + 2 * ROW_W + DIST_W + CNT_W + FILT_W;
  localparam int M_TDATA_W      = 112;
  localparam int M_PAD_W        = M_TDATA_W - M_PAYLOAD_W;
  localparam int MAX_POINTS_DEF = 1024;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PAIR  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_ACCEPTED     = 3'd0,
    ST_OUT_OF_RANGE = 3'd1,
    ST_FILTERED     = 3'd2,
    ST_CAP_FULL     = 3'd3,
    ST_NOT_FINITE   = 3'd4,
    ST_IGNORED      = 3'd5,
    ST_STARTED      = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS_LIMIT  = 3'd0,
    CFG_MIN_WEIGHT    = 3'd1,
    CFG_DEGREE_CAP    = 3'd2,
    CFG_EDGE_CAPACITY = 3'd3,
    CFG_FILTER_EN     = 3'd4,
    CFG_EARLY_STOP_EN = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DIST_W-1:0] radius_limit;
    logic [MINW_W-1:0]        min_weight;
    logic [DEG_W-1:0]         degree_cap;
    logic [CNT_W-1:0]         edge_capacity;
    logic                     filter_en;
    logic                     early_stop_en;
  } cfg_t;

endpackage

@@ rtl/core/refdc_cfg.sv @@
// Configuration register file for the radius edge filter.
// Depends on refdc_pkg for the register codes and the cfg_t struct.
module refdc_cfg
  import refdc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius_limit  <= 32'sh7FFF_FFFF;
      cfg_q.min_weight    <= '0;
      cfg_q.degree_cap    <= 16'hFFFF;
      cfg_q.edge_capacity <= 17'h10000;
      cfg_q.filter_en     <= 1'b0;
      cfg_q.early_stop_en <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RADIUS_LIMIT:  cfg_q.radius_limit  <= $signed(cfg_data_i);
        CFG_MIN_WEIGHT:    cfg_q.min_weight    <= cfg_data_i[MINW_W-1:0];
        CFG_DEGREE_CAP:    cfg_q.degree_cap    <= cfg_data_i[DEG_W-1:0];
        CFG_EDGE_CAPACITY: cfg_q.edge_capacity <= cfg_data_i[CNT_W-1:0];
        CFG_FILTER_EN:     cfg_q.filter_en     <= cfg_data_i[0];
        CFG_EARLY_STOP_EN: cfg_q.early_stop_en <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/refdc_deg_mem.sv @@
// Per-point degree memory: one write port, two read ports, registered read data.
// Depends on refdc_pkg for the degree width.
module refdc_deg_mem
  import refdc_pkg::*;
#(
  parameter int  DEPTH = MAX_POINTS_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_a_i,
  input  logic [AW-1:0]    rd_addr_b_i,
  output logic [DEG_W-1:0] rd_data_a_o,
  output logic [DEG_W-1:0] rd_data_b_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [DEG_W-1:0] wr_data_i
);

  logic [DEG_W-1:0] mem_q [DEPTH];
  logic [DEG_W-1:0] rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read-before-write: a read at the write address returns the old word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

@@ rtl/core/radius_edge_filter_degree_cap_unit.sv @@
// Top level of the radius edge filter with per-point degree cap.
// Depends on refdc_pkg, refdc_cfg and refdc_deg_mem.
//
// Each transfer on the input stream is a start item or an upper-triangle pair; each gives
// exactly one result, which passes the evaluation stage and the output register. Pairs
// sustain one per cycle while no write-back is due and the output is free. Point degrees
// live in a memory with one write port and two read ports; the degree of the point last
// used as an edge row is held in a register, so the write port only carries the column
// update. An accepted edge whose row differs from the held row first writes the held
// degree back, which stalls the evaluation stage. A start item, and likewise reset, runs
// a clearing pass over the degree memory, during which no input is taken; configuration
// writes go through at any time. Point indices are reduced modulo MAX_POINTS.
module radius_edge_filter_degree_cap_unit
  import refdc_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: row[9:0], col[19:10], distance[51:20], zero pad
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: kind[0], not_finite[1]
  input  logic [S_TUSER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: edge_slot[15:0], edge_row[25:16], edge_col[35:26], edge_weight[67:36],
  //        edges_so_far[84:68], filtered_count[104:85], zero pad
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // tuser: status[2:0]
  output logic [ST_W-1:0]       m_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PTR_W = $clog2(MAX_POINTS);

  // point index modulo MAX_POINTS by restoring subtraction of shifted multiples
  function automatic logic [PTR_W-1:0] wrap_idx(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] r;
    r = v;
    for (int k = ROW_W - 1; k >= 0; k--) begin
      if ((MAX_POINTS << k) < (1 << ROW_W)) begin
        if (r >= ROW_W'(MAX_POINTS << k)) begin
          r = r - ROW_W'(MAX_POINTS << k);
        end
      end
    end
    return PTR_W'(r);
  endfunction

  function automatic logic [DEG_W-1:0] sat_inc(input logic [DEG_W-1:0] d,
                                               input logic [DEG_W-1:0] cap);
    return (d < cap) ? d + DEG_W'(1) : d;
  endfunction

  cfg_t cfg;

  refdc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input unpacking
  logic              in_kind, in_nf;
  logic [ROW_W-1:0]  in_row, in_col;
  logic [DIST_W-1:0] in_dist;
  logic              in_fire;

  assign in_kind = s_axis_tuser[0];
  assign in_nf   = s_axis_tuser[1];
  assign in_row  = s_axis_tdata[ROW_W-1:0];
  assign in_col  = s_axis_tdata[2*ROW_W-1:ROW_W];
  assign in_dist = s_axis_tdata[2*ROW_W+DIST_W-1:2*ROW_W];
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // degree memory
  logic [DEG_W-1:0] mem_rd_r, mem_rd_c;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [DEG_W-1:0] wr_data;

  refdc_deg_mem #(
    .DEPTH (MAX_POINTS)
  ) u_deg_mem (
    .clk_i       (clk_i),
    .rd_en_i     (in_fire),
    .rd_addr_a_i (wrap_idx(in_row)),
    .rd_addr_b_i (wrap_idx(in_col)),
    .rd_data_a_o (mem_rd_r),
    .rd_data_b_o (mem_rd_c),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data)
  );

  // evaluation stage
  logic                     s1_vld_q, s1_first_q;
  logic                     s1_kind_q, s1_nf_q;
  logic [ROW_W-1:0]         s1_row_q, s1_col_q;
  logic signed [DIST_W-1:0] s1_dist_q;
  logic [PTR_W-1:0]         s1_ar_q, s1_ac_q;
  logic [DEG_W-1:0]         held_r_q, held_c_q;

  // last memory write, not yet visible in the read data of the stage
  logic             fw_vld_q;
  logic [PTR_W-1:0] fw_addr_q;
  logic [DEG_W-1:0] fw_data_q;

  // held row degree
  logic             cache_vld_q, cache_vld_d;
  logic [PTR_W-1:0] cache_row_q, cache_row_d;
  logic [DEG_W-1:0] cache_deg_q, cache_deg_d;

  // run state
  logic [CNT_W-1:0]  edge_cnt_q, edge_cnt_d;
  logic [FILT_W-1:0] filt_q, filt_d;
  logic [ROW_W-1:0]  prev_row_q, prev_row_d;
  logic              done_q, done_d, err_q, err_d;
  logic              clr_q, clr_d;
  logic [PTR_W-1:0]  clr_cnt_q, clr_cnt_d;

  // output register
  logic              out_vld_q;
  status_e           out_st_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [ROW_W-1:0]  out_row_q, out_col_q;
  logic [DIST_W-1:0] out_weight_q;
  logic [CNT_W-1:0]  out_edges_q;
  logic [FILT_W-1:0] out_filt_q;

  logic [DEG_W-1:0] src_r, src_c, eff_r, eff_c, deg_r, deg_c;

  always_comb begin
    src_r = s1_first_q ? mem_rd_r : held_r_q;
    src_c = s1_first_q ? mem_rd_c : held_c_q;
    eff_r = (fw_vld_q && fw_addr_q == s1_ar_q) ? fw_data_q : src_r;
    eff_c = (fw_vld_q && fw_addr_q == s1_ac_q) ? fw_data_q : src_c;
    deg_r = (cache_vld_q && cache_row_q == s1_ar_q) ? cache_deg_q : eff_r;
    deg_c = (cache_vld_q && cache_row_q == s1_ac_q) ? cache_deg_q : eff_c;
  end

  status_e st;
  logic    take_edge, set_done, set_err, upd_prev, bump_filt;
  logic    cap_full, above_max, below_min;
  logic    wb_need, s1_fire;

  assign cap_full  = edge_cnt_q >= cfg.edge_capacity;
  assign above_max = s1_dist_q > $signed(cfg.radius_limit);
  assign below_min = $signed({s1_dist_q[DIST_W-1], s1_dist_q})
                   < $signed({2'b00, cfg.min_weight});

  always_comb begin
    st        = ST_IGNORED;
    take_edge = 1'b0;
    set_done  = 1'b0;
    set_err   = 1'b0;
    upd_prev  = 1'b0;
    bump_filt = 1'b0;
    priority if (s1_kind_q == KIND_START) begin
      st = ST_STARTED;
    end else if (done_q || err_q) begin
      st = ST_IGNORED;
    end else if (cfg.early_stop_en && s1_row_q != prev_row_q && cap_full) begin
      set_done = 1'b1;
      st       = ST_IGNORED;
    end else begin
      upd_prev = 1'b1;
      priority if (s1_nf_q) begin
        set_err = 1'b1;
        st      = ST_NOT_FINITE;
      end else if (above_max || below_min) begin
        st = ST_OUT_OF_RANGE;
      end else if (cfg.filter_en &&
                   (deg_r >= cfg.degree_cap || deg_c >= cfg.degree_cap)) begin
        bump_filt = 1'b1;
        st        = ST_FILTERED;
      end else if (cap_full) begin
        set_done = cfg.early_stop_en;
        st       = ST_CAP_FULL;
      end else begin
        take_edge = 1'b1;
        st        = ST_ACCEPTED;
      end
    end
  end

  // a new edge row needs the held degree written back first
  assign wb_need = s1_vld_q && take_edge && cache_vld_q && (cache_row_q != s1_ar_q);
  assign s1_fire = s1_vld_q && !wb_need && (!out_vld_q || m_axis_tready);

  assign s_axis_tready = !clr_q && (!s1_vld_q || (s1_fire && s1_kind_q == KIND_PAIR));

  // write port: clearing pass, write-back of the held row, column update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_q;
    wr_data = '0;
    priority if (clr_q) begin
      wr_en = 1'b1;
    end else if (wb_need) begin
      wr_en   = 1'b1;
      wr_addr = cache_row_q;
      wr_data = cache_deg_q;
    end else if (s1_fire && take_edge && s1_ar_q != s1_ac_q) begin
      wr_en   = 1'b1;
      wr_addr = s1_ac_q;
      wr_data = sat_inc(deg_c, cfg.degree_cap);
    end else begin
      wr_en = 1'b0;
    end
  end

  always_comb begin
    cache_vld_d = cache_vld_q;
    cache_row_d = cache_row_q;
    cache_deg_d = cache_deg_q;
    priority if (s1_fire && s1_kind_q == KIND_START) begin
      cache_vld_d = 1'b0;
    end else if (wb_need) begin
      cache_vld_d = 1'b0;
    end else if (s1_fire && take_edge) begin
      cache_vld_d = 1'b1;
      cache_row_d = s1_ar_q;
      cache_deg_d = (s1_ar_q == s1_ac_q)
                  ? sat_inc(sat_inc(deg_r, cfg.degree_cap), cfg.degree_cap)
                  : sat_inc(deg_r, cfg.degree_cap);
    end else begin
      cache_vld_d = cache_vld_q;
    end
  end

  always_comb begin
    edge_cnt_d = edge_cnt_q;
    filt_d     = filt_q;
    prev_row_d = prev_row_q;
    done_d     = done_q;
    err_d      = err_q;
    clr_d      = clr_q;
    clr_cnt_d  = clr_cnt_q;
    if (s1_fire) begin
      if (s1_kind_q == KIND_START) begin
        edge_cnt_d = '0;
        filt_d     = '0;
        prev_row_d = '0;
        done_d     = 1'b0;
        err_d      = 1'b0;
        clr_d      = 1'b1;
        clr_cnt_d  = '0;
      end else begin
        if (take_edge) edge_cnt_d = edge_cnt_q + CNT_W'(1);
        if (bump_filt && filt_q != '1) filt_d = filt_q + FILT_W'(1);
        if (upd_prev) prev_row_d = s1_row_q;
        if (set_done) done_d = 1'b1;
        if (set_err) err_d = 1'b1;
      end
    end
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + PTR_W'(1);
      if (clr_cnt_q == PTR_W'(MAX_POINTS - 1)) clr_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s1_first_q  <= 1'b0;
      fw_vld_q    <= 1'b0;
      cache_vld_q <= 1'b0;
      edge_cnt_q  <= '0;
      filt_q      <= '0;
      prev_row_q  <= '0;
      done_q      <= 1'b0;
      err_q       <= 1'b0;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_q   <= 1'b1;
        s1_first_q <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end else if (s1_vld_q) begin
        s1_first_q <= 1'b0;
      end
      fw_vld_q    <= wr_en && !clr_q;
      cache_vld_q <= cache_vld_d;
      edge_cnt_q  <= edge_cnt_d;
      filt_q      <= filt_d;
      prev_row_q  <= prev_row_d;
      done_q      <= done_d;
      err_q       <= err_d;
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      if (s1_fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= in_kind;
      s1_nf_q   <= in_nf;
      s1_row_q  <= in_row;
      s1_col_q  <= in_col;
      s1_dist_q <= $signed(in_dist);
      s1_ar_q   <= wrap_idx(in_row);
      s1_ac_q   <= wrap_idx(in_col);
    end
    // a stalled item folds pending writes into its own copy of the degrees
    if (!in_fire && s1_vld_q && !s1_fire) begin
      held_r_q <= eff_r;
      held_c_q <= eff_c;
    end
    fw_addr_q   <= wr_addr;
    fw_data_q   <= wr_data;
    cache_row_q <= cache_row_d;
    cache_deg_q <= cache_deg_d;
    if (s1_fire) begin
      out_st_q     <= st;
      out_slot_q   <= take_edge ? edge_cnt_q[SLOT_W-1:0] : '0;
      out_row_q    <= take_edge ? s1_row_q : '0;
      out_col_q    <= take_edge ? s1_col_q : '0;
      out_weight_q <= take_edge ? s1_dist_q : '0;
      out_edges_q  <= edge_cnt_d;
      out_filt_q   <= filt_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_filt_q, out_edges_q, out_weight_q,
                          out_col_q, out_row_q, out_slot_q};

  // no input is taken while the degree memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready)
    else $error("input transfer during clearing pass");

  // a write-back always releases the held row
  a_wb_releases_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_need |=> !cache_vld_q)
    else $error("held row still valid after write-back");

  // an accepted edge reports its slot one below the running count
  a_slot_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_st_q == ST_ACCEPTED) |->
      out_edges_q[SLOT_W-1:0] == out_slot_q + SLOT_W'(1))
    else $error("edge slot and edge count disagree");

  // the evaluation stage only waits for a write-back or a busy output
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_fire && !wb_need) |-> (out_vld_q && !m_axis_tready))
    else $error("evaluation stage stalled without cause");

endmodule
